@@ rtl/core/ced_pkg.sv @@
package ced_pkg;

	// decoder phase: plain text, after backslash, inside \x, inside octal
	typedef enum logic [1:0] {
		PH_PLAIN = 2'd0,
		PH_ESC   = 2'd1,
		PH_HEX   = 2'd2,
		PH_OCT   = 2'd3
	} phase_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;

	// up to two decoded bytes produced by one input word
	typedef struct packed {
		logic [7:0] b0;    // first byte
		logic       d0;    // first byte carries data (0: bare end marker)
		logic [7:0] b1;    // second byte
		logic       two;   // second byte present
		logic       last;  // end of string after this entry
	} word_pair_t;

endpackage

@@ rtl/core/ced_front.sv @@
module ced_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	input  logic                q_full,
	output logic                q_push,
	output ced_pkg::word_pair_t q_word
);

	ced_pkg::phase_t ph_q, nph;
	logic [7:0] pend_q, npend;
	logic [1:0] cnt_q, ncnt;

	logic       hx_ok;
	logic [3:0] hx_val;
	logic [7:0] oct_acc;
	logic       plain_mode;
	logic       fl_v, mn_v, end_v, d0, two;
	logic [7:0] mn_b, e0;
	logic       take;

	// hex digit decode
	always_comb begin
		hx_ok  = 1'b1;
		hx_val = 4'd0;
		case (in_byte) inside
			["0":"9"]: hx_val = in_byte[3:0];
			["a":"f"], ["A":"F"]: hx_val = in_byte[3:0] + 4'd9;
			default: hx_ok = 1'b0;
		endcase
	end

	assign oct_acc = {pend_q[4:0], in_byte[2:0]};

	always_comb begin
		nph        = ph_q;
		npend      = pend_q;
		ncnt       = cnt_q;
		fl_v       = 1'b0;
		mn_v       = 1'b0;
		mn_b       = in_byte;
		plain_mode = 1'b0;
		case (ph_q)
			ced_pkg::PH_PLAIN: plain_mode = 1'b1;
			ced_pkg::PH_ESC: begin
				nph  = ced_pkg::PH_PLAIN;
				mn_v = 1'b1;
				case (in_byte) inside
					"n": mn_b = 8'h0A;
					"t": mn_b = 8'h09;
					"r": mn_b = 8'h0D;
					"a": mn_b = 8'h07;
					"b": mn_b = 8'h08;
					"f": mn_b = 8'h0C;
					"v": mn_b = 8'h0B;
					"x": begin
						mn_v  = 1'b0;
						nph   = ced_pkg::PH_HEX;
						npend = 8'd0;
					end
					["0":"7"]: begin
						mn_v  = 1'b0;
						nph   = ced_pkg::PH_OCT;
						npend = {5'd0, in_byte[2:0]};
						ncnt  = 2'd1;
					end
					default: ;
				endcase
			end
			ced_pkg::PH_HEX: begin
				if (hx_ok) begin
					npend = {pend_q[3:0], hx_val};
				end else begin
					fl_v       = 1'b1;
					nph        = ced_pkg::PH_PLAIN;
					npend      = 8'd0;
					plain_mode = 1'b1;
				end
			end
			ced_pkg::PH_OCT: begin
				if (in_byte inside {["0":"7"]} && cnt_q != 2'd3) begin
					npend = oct_acc;
					ncnt  = cnt_q + 2'd1;
					if (cnt_q == 2'd2) begin
						// third digit closes the escape
						mn_v  = 1'b1;
						mn_b  = oct_acc;
						nph   = ced_pkg::PH_PLAIN;
						npend = 8'd0;
						ncnt  = 2'd0;
					end
				end else begin
					fl_v       = 1'b1;
					nph        = ced_pkg::PH_PLAIN;
					npend      = 8'd0;
					ncnt       = 2'd0;
					plain_mode = 1'b1;
				end
			end
			default: ;
		endcase
		if (plain_mode) begin
			if (in_byte == ced_pkg::CH_BSLASH) begin
				nph = ced_pkg::PH_ESC;
			end else begin
				mn_v = 1'b1;
				mn_b = in_byte;
			end
		end
	end

	// end of string flushes a pending numeric escape
	assign end_v = in_last && (nph == ced_pkg::PH_HEX || nph == ced_pkg::PH_OCT);

	// pack flush, main and end-flush bytes (at most two are present)
	assign d0  = fl_v | mn_v | end_v;
	assign two = (fl_v & mn_v) | (fl_v & end_v) | (mn_v & end_v);
	assign e0  = fl_v ? pend_q : (mn_v ? mn_b : npend);

	assign q_word.b0   = d0 ? e0 : 8'd0;
	assign q_word.d0   = d0;
	assign q_word.b1   = (fl_v && mn_v) ? mn_b : npend;
	assign q_word.two  = two;
	assign q_word.last = in_last;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign q_push   = take && (d0 || in_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= ced_pkg::PH_PLAIN;
			pend_q <= 8'd0;
			cnt_q  <= 2'd0;
		end else if (take) begin
			if (in_last) begin
				ph_q   <= ced_pkg::PH_PLAIN;
				pend_q <= 8'd0;
				cnt_q  <= 2'd0;
			end else begin
				ph_q   <= nph;
				pend_q <= npend;
				cnt_q  <= ncnt;
			end
		end
	end

endmodule

@@ rtl/core/ced_queue.sv @@
module ced_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ced_pkg::word_pair_t push_word,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output ced_pkg::word_pair_t head
);

	localparam logic [1:0] QDEPTH = 2'd2;

	ced_pkg::word_pair_t mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == QDEPTH);
	assign empty = (count_q == 2'd0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)      count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QDEPTH) else $error("queue count out of range");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 2'd1)
		else $error("queue count did not advance");
`endif

endmodule

@@ rtl/core/ced_back.sv @@
module ced_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  ced_pkg::word_pair_t q_head,
	output logic                q_pop,
	output logic                res_valid,
	input  logic                res_ready,
	output logic [7:0]          out_byte,
	output logic                out_valid,
	output logic                out_last
);

	logic sub_q;  // second byte of the head entry is on the port
	logic fire;
	logic final_word;

	assign res_valid  = !q_empty;
	assign fire       = res_valid && res_ready;
	assign final_word = sub_q || !q_head.two;
	assign q_pop      = fire && final_word;

	assign out_byte  = sub_q ? q_head.b1 : q_head.b0;
	assign out_valid = sub_q ? 1'b1 : q_head.d0;
	assign out_last  = q_head.last && final_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= 1'b0;
		end else if (fire) begin
			sub_q <= !final_word;
		end
	end

`ifndef SYNTH
	a_sub_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q |-> (res_valid && q_head.two)) else $error("second byte without pair");
	a_sub_held: assert property (@(posedge clk) disable iff (!arst_n)
		(sub_q && !res_ready) |=> sub_q) else $error("second byte dropped");
	a_pair_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && q_head.two && !sub_q) |-> !q_pop) else $error("pair popped early");
`endif

endmodule

@@ rtl/core/c_escape_sequence_decoder.sv @@
// C string escape decoder. Takes one raw byte of a string body per input
// word (in_last marks the final byte) and returns the decoded bytes:
// named escapes (\n \t \r \a \b \f \v \\ \' \" \?), \x with any number of hex
// digits, one to three octal digits, values kept to 8 bits; any other
// escaped byte passes as itself. The front stage decodes one word per
// cycle while the queue is not full and writes at most two result bytes
// into a two-entry queue; the back stage drains the queue one result
// word per cycle while res_ready is high. Sustained rate is one input
// word per cycle while each word yields at most one result and res_ready
// stays high; a word that yields two results (a numeric escape flushed by
// a following byte) needs two output handshakes. At the end of a string a
// pending numeric value is flushed, a lone trailing backslash is dropped,
// and if nothing is left to send a bare marker (out_valid = 0, out_byte = 0)
// carries out_last; res_valid comes from the queue, which registers results.
module c_escape_sequence_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [7:0] out_byte,
	output logic       out_valid,
	output logic       out_last
);

	ced_pkg::word_pair_t push_word, head;
	logic push, pop, full, empty;

	// front: escape parsing and state
	ced_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.q_full   (full),
		.q_push   (push),
		.q_word   (push_word)
	);

	// decoupling queue
	ced_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.head      (head)
	);

	// back: one result word per handshake
	ced_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (empty),
		.q_head    (head),
		.q_pop     (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.out_byte  (out_byte),
		.out_valid (out_valid),
		.out_last  (out_last)
	);

endmodule

@@ test/tb_c_escape_sequence_decoder.sv @@
module tb_c_escape_sequence_decoder;

	// cycles with no word moving on either side before we call it hung
	localparam int STALL_LIMIT = 2000;
	// drain time after the last expected result (pipe delay plus margin)
	localparam int TAIL_CYCLES = 10;

	// one raw byte of a string body as it goes to the input port
	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} raw_word_t;

	// one decoded result word as it should leave the output port
	typedef struct packed {
		logic [7:0] data;
		logic       has_data;
		logic       fin;
	} dec_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       out_last;

	c_escape_sequence_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.out_byte (out_byte),
		.out_valid(out_valid),
		.out_last (out_last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Decoder shadow: own copy of the escape state machine
	// ------------------------------------------------------------------
	ced_pkg::phase_t dec_phase = ced_pkg::PH_PLAIN;
	logic [7:0]  dec_value = 8'h00;   // numeric escape value so far
	logic [1:0]  oct_count = 2'd0;    // octal digits taken so far
	logic [7:0]  step_bytes [2];      // data bytes produced by the current word
	int          step_n;

	raw_word_t   raw_words [$];       // stimulus not yet driven
	dec_result_t expected_bytes [$];  // results still owed by the block

	int n_items = 0;
	int n_taken = 0;
	int n_errors = 0;
	int idle_cycles = 0;

	function automatic void note_byte(input logic [7:0] b);
		step_bytes[step_n] = b;
		step_n++;
	endfunction

	function automatic logic is_octal(input logic [7:0] c);
		return (c >= "0" && c <= "7");
	endfunction

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return -1;
	endfunction

	// plain text: backslash opens an escape, anything else goes straight out
	function automatic void take_plain(input logic [7:0] c);
		if (c == ced_pkg::CH_BSLASH) begin
			dec_phase = ced_pkg::PH_ESC;
		end else begin
			note_byte(c);
		end
	endfunction

	function automatic void close_numeric();
		note_byte(dec_value);
		dec_phase = ced_pkg::PH_PLAIN;
		dec_value = 8'h00;
		oct_count = 2'd0;
	endfunction

	// decode one accepted word and queue the result words it owes
	function automatic void decode_word(input logic [7:0] c, input logic fin);
		int h;
		int k;
		step_n = 0;
		case (dec_phase)
			ced_pkg::PH_PLAIN: begin
				take_plain(c);
			end
			ced_pkg::PH_ESC: begin
				dec_phase = ced_pkg::PH_PLAIN;
				case (c)
					"n": note_byte(8'h0A);
					"t": note_byte(8'h09);
					"r": note_byte(8'h0D);
					"a": note_byte(8'h07);
					"b": note_byte(8'h08);
					"f": note_byte(8'h0C);
					"v": note_byte(8'h0B);
					"x": begin
						dec_phase = ced_pkg::PH_HEX;
						dec_value = 8'h00;
					end
					default: begin
						// \\ \' \" \? and unknown escapes all pass as themselves
						if (is_octal(c)) begin
							dec_phase = ced_pkg::PH_OCT;
							dec_value = {5'd0, c[2:0]};
							oct_count = 2'd1;
						end else begin
							note_byte(c);
						end
					end
				endcase
			end
			ced_pkg::PH_HEX: begin
				h = hex_digit(c);
				if (h >= 0) begin
					// any number of digits; only the low byte survives
					dec_value = {dec_value[3:0], h[3:0]};
				end else begin
					// terminator flushes the value, then is decoded as text
					close_numeric();
					take_plain(c);
				end
			end
			default: begin
				if (is_octal(c) && oct_count < 2'd3) begin
					dec_value = {dec_value[4:0], c[2:0]};
					oct_count++;
					// third digit closes the escape on the spot
					if (oct_count == 2'd3) close_numeric();
				end else begin
					close_numeric();
					take_plain(c);
				end
			end
		endcase
		if (fin) begin
			// end of string: flush a numeric value, drop a lone backslash
			if (dec_phase == ced_pkg::PH_HEX || dec_phase == ced_pkg::PH_OCT)
				note_byte(dec_value);
			dec_phase = ced_pkg::PH_PLAIN;
			dec_value = 8'h00;
			oct_count = 2'd0;
		end
		if (fin && step_n == 0) begin
			expected_bytes.insert(expected_bytes.size(),
				'{data: 8'h00, has_data: 1'b0, fin: 1'b1});
		end else begin
			for (k = 0; k < step_n; k++)
				expected_bytes.insert(expected_bytes.size(),
					'{data: step_bytes[k], has_data: 1'b1,
					fin: fin && (k == step_n - 1)});
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------
	task automatic add_word(input logic [7:0] b, input logic fin);
		raw_words.insert(raw_words.size(), '{data: b, fin: fin});
		n_items++;
	endtask

	function automatic logic [7:0] pick_named();
		case ($urandom_range(0, 10))
			0: return "n";
			1: return "t";
			2: return "r";
			3: return "a";
			4: return "b";
			5: return "f";
			6: return "v";
			7: return ced_pkg::CH_BSLASH;
			8: return "'";
			9: return "\"";
			default: return "?";
		endcase
	endfunction

	function automatic logic [7:0] pick_hex();
		case ($urandom_range(0, 2))
			0: return 8'("0" + $urandom_range(0, 9));
			1: return 8'("a" + $urandom_range(0, 5));
			default: return 8'("A" + $urandom_range(0, 5));
		endcase
	endfunction

	// one string body built from well-formed pieces with random content
	task automatic add_string(input int n_piece);
		logic [7:0] s [$];
		int p;
		int d;
		for (p = 0; p < n_piece; p++) begin
			case ($urandom_range(0, 8))
				0: s.insert(s.size(), 8'($urandom_range(0, 255)));
				1: s.insert(s.size(), 8'($urandom_range(32, 126)));
				2: begin
					s.insert(s.size(), ced_pkg::CH_BSLASH);
					s.insert(s.size(), pick_named());
				end
				3: begin
					// \x with zero up to five digits, longer runs wrap
					s.insert(s.size(), ced_pkg::CH_BSLASH);
					s.insert(s.size(), "x");
					for (d = $urandom_range(0, 5); d > 0; d--) s.insert(s.size(), pick_hex());
				end
				4, 5: begin
					// one to three octal digits, sometimes another decimal digit after
					s.insert(s.size(), ced_pkg::CH_BSLASH);
					for (d = $urandom_range(1, 3); d > 0; d--)
						s.insert(s.size(), 8'("0" + $urandom_range(0, 7)));
					if ($urandom_range(0, 2) == 0)
						s.insert(s.size(), 8'("0" + $urandom_range(0, 9)));
				end
				6: begin
					s.insert(s.size(), ced_pkg::CH_BSLASH);
					s.insert(s.size(), 8'($urandom_range(0, 255)));
				end
				7: s.insert(s.size(), 8'($urandom_range(128, 255)));
				default: s.insert(s.size(), ced_pkg::CH_BSLASH);
			endcase
		end
		// lone trailing backslash now and then
		if ($urandom_range(0, 5) == 0) s.insert(s.size(), ced_pkg::CH_BSLASH);
		for (p = 0; p < s.size(); p++) add_word(s[p], p == s.size() - 1);
	endtask

	// ------------------------------------------------------------------
	// Handshake pacing
	// ------------------------------------------------------------------
	logic calm = 1'b0;          // no idling at all while set
	int   calm_count = 0;

	function automatic int draw_wait();
		if (calm || $urandom_range(0, 1) == 0) return 0;
		return $urandom_range(0, 12);
	endfunction

	logic in_took = 1'b0;       // input word accepted at the last rising edge
	logic out_took = 1'b0;      // result word accepted at the last rising edge
	int   send_wait = 0;
	int   hold_wait = 0;
	raw_word_t next_word;

	// driver: new word only once the previous one is gone and its gap is served
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_took) begin
			if (send_wait > 0) begin
				in_valid <= 1'b0;
				send_wait--;
			end else if (raw_words.size() != 0) begin
				next_word = raw_words.pop_front();
				in_byte <= next_word.data;
				in_last <= next_word.fin;
				in_valid <= 1'b1;
				send_wait = draw_wait();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall a random count after each taken result
	always @(negedge clk) begin
		if (out_took) hold_wait = draw_wait();
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else if (hold_wait > 0) begin
			res_ready <= 1'b0;
			hold_wait--;
		end else begin
			res_ready <= 1'b1;
		end
	end

	// monitor: predict on input acceptance, compare on output acceptance
	dec_result_t want;
	always @(posedge clk) begin
		in_took <= arst_n && in_valid && in_ready;
		out_took <= arst_n && res_valid && res_ready;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				decode_word(in_byte, in_last);
				n_taken++;
			end
			if (res_valid && res_ready) begin
				if (expected_bytes.size() == 0) begin
					$display("%0t: unexpected result: byte %h valid %b last %b",
						$time, out_byte, out_valid, out_last);
					n_errors++;
				end else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want.data) begin
						$display("%0t: out_byte expected %h got %h", $time, want.data, out_byte);
						n_errors++;
					end
					if (out_valid !== want.has_data) begin
						$display("%0t: out_valid expected %b got %b",
							$time, want.has_data, out_valid);
						n_errors++;
					end
					if (out_last !== want.fin) begin
						$display("%0t: out_last expected %b got %b", $time, want.fin, out_last);
						n_errors++;
					end
				end
			end
			if ((in_valid && in_ready) || (res_valid && res_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			// switch between bursts with no gaps and randomly gapped stretches
			if (calm_count == 0) begin
				calm <= ($urandom_range(0, 3) == 0);
				calm_count <= $urandom_range(40, 200);
			end else begin
				calm_count <= calm_count - 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence: stimulus, reset, run, drain, verdict
	// ------------------------------------------------------------------
	initial begin
		logic timed_out;
		int   r;
		timed_out = 1'b0;

		// extremes of the byte field, plain text
		add_word(8'h00, 1'b0);
		add_word(8'hFF, 1'b1);
		// named escape
		add_word(ced_pkg::CH_BSLASH, 1'b0);
		add_word("n", 1'b0);
		// hex escape ended by a non-hex byte: flush plus the byte itself
		add_word(ced_pkg::CH_BSLASH, 1'b0);
		add_word("x", 1'b0);
		add_word("4", 1'b0);
		add_word("1", 1'b0);
		add_word("g", 1'b0);
		// third octal digit closes the escape at once
		add_word(ced_pkg::CH_BSLASH, 1'b0);
		add_word("1", 1'b0);
		add_word("2", 1'b0);
		add_word("3", 1'b0);
		// octal ended by a backslash, which opens an unknown escape
		add_word(ced_pkg::CH_BSLASH, 1'b0);
		add_word("7", 1'b0);
		add_word(ced_pkg::CH_BSLASH, 1'b0);
		add_word("q", 1'b1);
		// \x with no digits at end of string gives zero
		add_word(ced_pkg::CH_BSLASH, 1'b0);
		add_word("x", 1'b1);
		// lone trailing backslash: bare end marker only
		add_word(ced_pkg::CH_BSLASH, 1'b1);
		// high byte after a backslash
		add_word(ced_pkg::CH_BSLASH, 1'b0);
		add_word(8'hC8, 1'b1);
		// octal flushed by a non-octal last byte: two results, last on the second
		add_word(ced_pkg::CH_BSLASH, 1'b0);
		add_word("5", 1'b0);
		add_word("8", 1'b1);

		// random: mostly well-formed strings, some raw noise
		while (n_items < 825) begin
			if ($urandom_range(0, 6) != 0) begin
				add_string($urandom_range(1, 6));
			end else begin
				for (r = $urandom_range(1, 4); r > 0; r--)
					add_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!timed_out && !(n_taken == n_items && expected_bytes.size() == 0)) begin
			@(negedge clk);
			if (idle_cycles >= STALL_LIMIT) timed_out = 1'b1;
		end
		if (!timed_out) repeat (TAIL_CYCLES) @(negedge clk);

		if (!timed_out && n_errors == 0 && expected_bytes.size() == 0) begin
			$display("tb_c_escape_sequence_decoder OK");
		end else begin
			$display("tb_c_escape_sequence_decoder NOT OK");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/ced_pkg.sv
rtl/core/ced_front.sv
rtl/core/ced_queue.sv
rtl/core/ced_back.sv
rtl/core/c_escape_sequence_decoder.sv
test/tb_c_escape_sequence_decoder.sv
